// ----- rtl/core/rle_sprite_blit_decoder_macros.svh -----
// Assertion macros shared by the run-length sprite decoder RTL.
// The macros expect signals named clk and rst in the including module.
`ifndef RLE_SPRITE_BLIT_DECODER_MACROS_SVH
`define RLE_SPRITE_BLIT_DECODER_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define RSBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that also has to hold while reset is applied.
`define RSBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/rsbd_pkg.sv -----
// Shared types and constants of the run-length sprite decoder.
// No dependencies; the parser and the decoder top import this package.
package rsbd_pkg;

  localparam int PIXEL_ADDR_W = 24;
  localparam int COLOR_W      = 16;
  localparam int ALPHA_W      = 8;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 2;
  localparam int DIM_W        = 13;
  localparam int COUNT_W      = 16;

  localparam logic [ALPHA_W-1:0] OPAQUE_ALPHA = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd320;

  // Parser phase codes.
  localparam logic [2:0] PH_SKIP_LO = 3'd0;
  localparam logic [2:0] PH_SKIP_HI = 3'd1;
  localparam logic [2:0] PH_RUN_LO  = 3'd2;
  localparam logic [2:0] PH_RUN_HI  = 3'd3;
  localparam logic [2:0] PH_COL_LO  = 3'd4;
  localparam logic [2:0] PH_COL_HI  = 3'd5;
  localparam logic [2:0] PH_ALPHA   = 3'd6;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       mode;
    logic       stream_start;
    logic       stream_last;
  } stream_item_t;

  typedef struct packed {
    logic [PIXEL_ADDR_W-1:0] pixel_address;
    logic [COLOR_W-1:0]      pixel_color;
    logic [ALPHA_W-1:0]      pixel_alpha;
    logic                    blend_needed;
  } pixel_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] start_address;
    logic [DIM_W-1:0]      row_stride;
    logic [DIM_W-1:0]      row_pitch;
  } cfg_t;

endpackage

// ----- rtl/core/rsbd_if.sv -----
// Valid/ready channel interfaces for the stream bytes and the pixel writes.
// Depends on nothing; payload fields follow the widths in rsbd_pkg.
interface rsbd_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       mode;
  logic       stream_start;
  logic       stream_last;

  modport source (output valid, stream_byte, mode, stream_start, stream_last, input ready);
  modport sink (input valid, stream_byte, mode, stream_start, stream_last, output ready);
endinterface

interface rsbd_pixel_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_address;
  logic [15:0] pixel_color;
  logic [7:0]  pixel_alpha;
  logic        blend_needed;

  modport source (output valid, pixel_address, pixel_color, pixel_alpha, blend_needed,
                  input ready);
  modport sink (input valid, pixel_address, pixel_color, pixel_alpha, blend_needed,
                output ready);
endinterface

// ----- rtl/core/rsbd_parser.sv -----
// Record parser and position tracker: holds the parse state, column and address.
// Depends on rsbd_pkg and the assertion macros header.
`include "rle_sprite_blit_decoder_macros.svh"

module rsbd_parser
  import rsbd_pkg::*;
#(
  parameter int ADDR_BITS   = 24,
  parameter int COLUMN_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  stream_item_t item,
  input  cfg_t         cfg,
  output logic         emit,
  output pixel_t       pixel
);

  localparam int SUM_W = ((COLUMN_BITS > COUNT_W) ? COLUMN_BITS : COUNT_W) + 1;

  logic [2:0]             phase, phase_next;
  logic [7:0]             low_hold, low_hold_next;
  logic [COLOR_W-1:0]     color_hold, color_hold_next;
  logic [COUNT_W-1:0]     run_rem, run_rem_next;
  logic [COLUMN_BITS-1:0] column, column_next;
  logic [ADDR_BITS-1:0]   waddr, waddr_next;

  // Values as seen after a stream start has been applied.
  logic [2:0]             phase_eff;
  logic [COUNT_W-1:0]     run_eff;
  logic [COLUMN_BITS-1:0] column_eff;
  logic [ADDR_BITS-1:0]   waddr_eff;

  logic                   adv_en;
  logic [COUNT_W-1:0]     adv_n;
  logic [SUM_W-1:0]       col_sum, col_adj;
  logic                   wrap;
  logic signed [DIM_W:0]  wrap_delta;
  logic [ADDR_BITS-1:0]   addr_adv;
  logic [COLOR_W-1:0]     word;
  logic [COUNT_W-1:0]     run_dec;

  assign phase_eff  = item.stream_start ? PH_SKIP_LO : phase;
  assign run_eff    = item.stream_start ? '0 : run_rem;
  assign column_eff = item.stream_start ? '0 : column;
  assign waddr_eff  = item.stream_start ? ADDR_BITS'(cfg.start_address) : waddr;

  assign word    = {item.stream_byte, low_hold};
  assign run_dec = run_eff - COUNT_W'(1);

  // Single row-wrap check: at most one pitch is taken off the column.
  assign col_sum    = SUM_W'(column_eff) + SUM_W'(adv_n);
  assign wrap       = col_sum >= SUM_W'(cfg.row_pitch);
  assign col_adj    = wrap ? col_sum - SUM_W'(cfg.row_pitch) : col_sum;
  assign wrap_delta = $signed({1'b0, cfg.row_stride}) - $signed({1'b0, cfg.row_pitch});
  assign addr_adv   = waddr_eff + ADDR_BITS'(adv_n)
                    + (wrap ? {{(ADDR_BITS-DIM_W-1){wrap_delta[DIM_W]}}, wrap_delta}
                            : '0);

  always_comb begin
    phase_next      = phase_eff;
    low_hold_next   = low_hold;
    color_hold_next = color_hold;
    run_rem_next    = run_eff;
    adv_en          = 1'b0;
    adv_n           = '0;
    emit            = 1'b0;
    pixel.pixel_address = PIXEL_ADDR_W'(waddr_eff);
    pixel.pixel_color   = color_hold;
    pixel.pixel_alpha   = OPAQUE_ALPHA;
    pixel.blend_needed  = 1'b0;

    unique case (phase_eff)
      PH_SKIP_HI: begin
        adv_en     = 1'b1;
        adv_n      = word;
        phase_next = PH_RUN_LO;
      end
      PH_RUN_LO: begin
        low_hold_next = item.stream_byte;
        phase_next    = PH_RUN_HI;
      end
      PH_RUN_HI: begin
        run_rem_next = word;
        phase_next   = (word == '0) ? PH_SKIP_LO : PH_COL_LO;
      end
      PH_COL_LO: begin
        low_hold_next = item.stream_byte;
        phase_next    = PH_COL_HI;
      end
      PH_COL_HI: begin
        color_hold_next   = word;
        pixel.pixel_color = word;
        if (item.mode) begin
          phase_next = PH_ALPHA;
        end else begin
          emit = 1'b1;
        end
      end
      PH_ALPHA: begin
        emit               = 1'b1;
        pixel.pixel_alpha  = item.stream_byte;
        pixel.blend_needed = 1'b1;
      end
      default: begin
        low_hold_next = item.stream_byte;
        phase_next    = PH_SKIP_HI;
      end
    endcase

    if (emit) begin
      adv_en       = 1'b1;
      adv_n        = COUNT_W'(1);
      run_rem_next = run_dec;
      phase_next   = (run_dec == '0) ? PH_SKIP_LO : PH_COL_LO;
    end

    column_next = adv_en ? col_adj[COLUMN_BITS-1:0] : column_eff;
    waddr_next  = adv_en ? addr_adv : waddr_eff;

    // The last byte drops any partial record.
    if (item.stream_last) begin
      phase_next   = PH_SKIP_LO;
      run_rem_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP_LO;
      low_hold   <= '0;
      color_hold <= '0;
      run_rem    <= '0;
      column     <= '0;
      waddr      <= '0;
    end else if (step) begin
      phase      <= phase_next;
      low_hold   <= low_hold_next;
      color_hold <= color_hold_next;
      run_rem    <= run_rem_next;
      column     <= column_next;
      waddr      <= waddr_next;
    end
  end

  `RSBD_ASSERT(a_emit_phase, (step && emit) |=> (phase == PH_SKIP_LO || phase == PH_COL_LO), "phase after a pixel is neither a new record nor the next color")
  `RSBD_ASSERT(a_last_idle, (step && item.stream_last) |=> (phase == PH_SKIP_LO && run_rem == '0), "parser not idle after the last byte")
  `RSBD_ASSERT(a_run_live, (phase == PH_COL_LO || phase == PH_COL_HI || phase == PH_ALPHA) |-> (run_rem != '0), "pixel phase entered with an empty run")

endmodule

// ----- rtl/core/rle_sprite_blit_decoder.sv -----
// A pixel write appears on the output in the cycle after its last stream byte is taken.
// Throughput: one stream byte per cycle; the only limit is the single output register,
// which accepts a new byte whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous): parser idles expecting a skip word, column and address clear,
// the output empties, and the registers return to address 0, stride 320 and pitch 320.
`include "rle_sprite_blit_decoder_macros.svh"

module rle_sprite_blit_decoder
  import rsbd_pkg::*;
#(
  parameter int ADDR_BITS   = 24,
  parameter int COLUMN_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  rsbd_stream_if.sink            stream,
  rsbd_pixel_if.source           pixels,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] register_index,
  input  logic [CFG_DATA_W-1:0]  write_data
);

  cfg_t         cfg;
  stream_item_t item;
  pixel_t       pixel, out_pixel;
  logic         emit;
  logic         accept;
  logic         out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address <= '0;
      cfg.row_stride    <= DIM_RESET;
      cfg.row_pitch     <= DIM_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        REG_START_ADDRESS: cfg.start_address <= write_data;
        REG_ROW_STRIDE:    cfg.row_stride    <= write_data[DIM_W-1:0];
        REG_ROW_PITCH:     cfg.row_pitch     <= write_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.stream_byte  = stream.stream_byte;
  assign item.mode         = stream.mode;
  assign item.stream_start = stream.stream_start;
  assign item.stream_last  = stream.stream_last;

  assign stream.ready = !out_valid || pixels.ready;
  assign accept       = stream.valid && stream.ready;

  rsbd_parser #(
    .ADDR_BITS   (ADDR_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .item  (item),
    .cfg   (cfg),
    .emit  (emit),
    .pixel (pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_pixel <= pixel;
    end
  end

  assign pixels.valid         = out_valid;
  assign pixels.pixel_address = out_pixel.pixel_address;
  assign pixels.pixel_color   = out_pixel.pixel_color;
  assign pixels.pixel_alpha   = out_pixel.pixel_alpha;
  assign pixels.blend_needed  = out_pixel.blend_needed;

  `RSBD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output register holds a pixel after reset")
  `RSBD_ASSERT(a_emit_shows, (accept && emit) |=> out_valid, "decoded pixel did not reach the output register")
  `RSBD_ASSERT(a_no_phantom, (accept && !emit) |=> !out_valid, "output shows a pixel that no byte produced")

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for rle_sprite_blit_decoder: random sprite streams go in
// over the stream channel and every pixel write is checked against a local decoder.
// Depends on rsbd_pkg, the rsbd_if channel interfaces and the decoder RTL.
module testbench
  import rsbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic write_enable;
  logic [CFG_INDEX_W-1:0] register_index;
  logic [CFG_DATA_W-1:0] write_data;

  rsbd_stream_if stream_ch();
  rsbd_pixel_if pixel_ch();

  rle_sprite_blit_decoder DUT (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .pixels(pixel_ch),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data)
  );

  // Decoder state and register copies used to predict the pixel writes.
  logic [CFG_DATA_W-1:0] origin_address;
  logic [DIM_W-1:0] fb_stride;
  logic [DIM_W-1:0] sprite_pitch;
  logic [2:0] parse_state;
  logic [7:0] byte_low;
  logic [COLOR_W-1:0] color_word;
  logic [COUNT_W-1:0] pixels_left;
  logic [11:0] sprite_column;
  logic [PIXEL_ADDR_W-1:0] dest_address;

  stream_item_t bytes_to_send[$];
  stream_item_t sprite_bytes[$];
  pixel_t writes_due[$];

  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int errors;
  int gap_pct;
  bit stream_taken;
  bit sink_hold;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task report_error(input string what);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", what);
  endtask

  // Move the write position forward, wrapping the row at most once.
  function automatic void move_position(input logic [15:0] count);
    logic [17:0] sum;
    sum = {6'd0, sprite_column} + {2'd0, count};
    dest_address = dest_address + {8'd0, count};
    if (sum >= {5'd0, sprite_pitch}) begin
      sum = sum - {5'd0, sprite_pitch};
      dest_address = dest_address + {11'd0, fb_stride} - {11'd0, sprite_pitch};
    end
    sprite_column = sum[11:0];
  endfunction

  function automatic void write_pixel(output pixel_t px, input logic [7:0] alpha,
                                      input logic blend);
    px.pixel_address = dest_address;
    px.pixel_color = color_word;
    px.pixel_alpha = alpha;
    px.blend_needed = blend;
    move_position(16'd1);
    pixels_left = pixels_left - 16'd1;
    parse_state = (pixels_left == 16'd0) ? PH_SKIP_LO : PH_COL_LO;
  endfunction

  function automatic void decode_stream_byte(input stream_item_t it, output bit emits,
                                             output pixel_t px);
    logic [15:0] word;
    emits = 1'b0;
    px = '0;
    if (it.stream_start) begin
      sprite_column = '0;
      dest_address = origin_address;
      parse_state = PH_SKIP_LO;
      pixels_left = '0;
    end
    word = {it.stream_byte, byte_low};
    case (parse_state)
      PH_SKIP_HI: begin
        move_position(word);
        parse_state = PH_RUN_LO;
      end
      PH_RUN_LO: begin
        byte_low = it.stream_byte;
        parse_state = PH_RUN_HI;
      end
      PH_RUN_HI: begin
        pixels_left = word;
        parse_state = (word == 16'd0) ? PH_SKIP_LO : PH_COL_LO;
      end
      PH_COL_LO: begin
        byte_low = it.stream_byte;
        parse_state = PH_COL_HI;
      end
      PH_COL_HI: begin
        color_word = word;
        // The mode is only looked at on the color's high byte.
        if (it.mode) begin
          parse_state = PH_ALPHA;
        end else begin
          emits = 1'b1;
          write_pixel(px, OPAQUE_ALPHA, 1'b0);
        end
      end
      PH_ALPHA: begin
        emits = 1'b1;
        write_pixel(px, it.stream_byte, 1'b1);
      end
      default: begin
        byte_low = it.stream_byte;
        parse_state = PH_SKIP_HI;
      end
    endcase
    if (it.stream_last) begin
      parse_state = PH_SKIP_LO;
      pixels_left = '0;
    end
  endfunction

  // Stream driver: a new byte is offered only once the previous one was taken.
  always @(negedge clk) begin : drive_stream
    stream_item_t next_item;
    if (rst) begin
      stream_ch.valid <= 1'b0;
    end else if (!stream_ch.valid || stream_taken) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_item = bytes_to_send.pop_front();
        stream_ch.valid <= 1'b1;
        stream_ch.stream_byte <= next_item.stream_byte;
        stream_ch.mode <= next_item.mode;
        stream_ch.stream_start <= next_item.stream_start;
        stream_ch.stream_last <= next_item.stream_last;
      end else begin
        stream_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || sink_hold) begin
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // Monitor: check pixel writes, then predict from the accepted stream byte.
  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t due;
    pixel_t px;
    stream_item_t it;
    bit emits;
    if (rst) begin
      stream_taken <= 1'b0;
    end else begin
      stream_taken <= stream_ch.valid && stream_ch.ready;
      if (pixel_ch.valid && pixel_ch.ready) begin
        got = {pixel_ch.pixel_address, pixel_ch.pixel_color, pixel_ch.pixel_alpha,
               pixel_ch.blend_needed};
        if (writes_due.size() == 0) begin
          report_error($sformatf("pixel write to %06h with none due", got.pixel_address));
        end else begin
          due = writes_due.pop_front();
          if (got.pixel_address !== due.pixel_address)
            report_error($sformatf("address %06h, want %06h",
                                   got.pixel_address, due.pixel_address));
          if (got.pixel_color !== due.pixel_color)
            report_error($sformatf("color %04h at %06h, want %04h",
                                   got.pixel_color, due.pixel_address, due.pixel_color));
          if (got.pixel_alpha !== due.pixel_alpha)
            report_error($sformatf("alpha %02h at %06h, want %02h",
                                   got.pixel_alpha, due.pixel_address, due.pixel_alpha));
          if (got.blend_needed !== due.blend_needed)
            report_error($sformatf("blend %0b at %06h, want %0b",
                                   got.blend_needed, due.pixel_address, due.blend_needed));
        end
      end
      if (stream_ch.valid && stream_ch.ready) begin
        it = {stream_ch.stream_byte, stream_ch.mode, stream_ch.stream_start,
              stream_ch.stream_last};
        decode_stream_byte(it, emits, px);
        if (emits) writes_due.push_back(px);
        bytes_taken++;
      end
    end
  end

  task push_byte(input logic [7:0] b, input logic m, input logic s, input logic l);
    bytes_to_send.push_back({b, m, s, l});
    bytes_queued++;
  endtask

  task append_byte(input logic [7:0] b, input logic m);
    sprite_bytes.push_back({b, m, 1'b0, 1'b0});
  endtask

  task append_word(input logic [15:0] w);
    append_byte(w[7:0], 1'($urandom));
    append_byte(w[15:8], 1'($urandom));
  endtask

  // One sprite: mostly well-formed records, sometimes cut short or pure noise.
  task build_sprite();
    int run_len;
    int cut;
    logic [15:0] skip;
    logic [15:0] color;
    bit alpha_sprite;
    bit alpha_px;
    sprite_bytes.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6))
        sprite_bytes.push_back({8'($urandom), 1'($urandom), 1'($urandom_range(3) == 0),
                                1'($urandom_range(3) == 0)});
    end else begin
      alpha_sprite = 1'($urandom);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(9))
          0: skip = 16'($urandom);
          1, 2: skip = 16'($urandom_range(600));
          default: skip = 16'($urandom_range(40));
        endcase
        run_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        append_word(skip);
        append_word(16'(run_len));
        repeat (run_len) begin
          color = 16'($urandom);
          alpha_px = ($urandom_range(19) == 0) ? !alpha_sprite : alpha_sprite;
          append_byte(color[7:0], 1'($urandom));
          append_byte(color[15:8], alpha_px);
          if (alpha_px) append_byte(8'($urandom), 1'($urandom));
        end
      end
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, sprite_bytes.size());
        while (sprite_bytes.size() > cut) void'(sprite_bytes.pop_back());
      end
      sprite_bytes[0].stream_start = 1'b1;
      if ($urandom_range(19) != 0) sprite_bytes[sprite_bytes.size() - 1].stream_last = 1'b1;
    end
    foreach (sprite_bytes[i]) begin
      bytes_to_send.push_back(sprite_bytes[i]);
      bytes_queued++;
    end
  endtask

  task write_register(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    register_index <= index;
    write_data <= data;
    case (index)
      REG_START_ADDRESS: origin_address = data;
      REG_ROW_STRIDE: fb_stride = data[DIM_W-1:0];
      REG_ROW_PITCH: sprite_pitch = data[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task wait_until_idle();
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (writes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The receiver stops for a long stretch so the output register backs up.
  initial begin
    sink_hold = 1'b0;
    while (bytes_taken < 500) @(posedge clk);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin
    #4ms;
    $display("rle_sprite_blit_decoder test failed");
    $finish;
  end

  initial begin : stimulus
    logic [23:0] start_val;
    logic [12:0] stride_val;
    logic [12:0] pitch_val;
    int unsigned phase_goal;
    rst = 1'b1;
    write_enable = 1'b0;
    register_index = '0;
    write_data = '0;
    stream_ch.valid = 1'b0;
    stream_ch.stream_byte = '0;
    stream_ch.mode = 1'b0;
    stream_ch.stream_start = 1'b0;
    stream_ch.stream_last = 1'b0;
    pixel_ch.ready = 1'b0;
    errors = 0;
    gap_pct = 13;
    bytes_queued = 0;
    bytes_taken = 0;
    origin_address = '0;
    fb_stride = DIM_RESET;
    sprite_pitch = DIM_RESET;
    parse_state = PH_SKIP_LO;
    byte_low = '0;
    color_word = '0;
    pixels_left = '0;
    sprite_column = '0;
    dest_address = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings. Largest skip, then a zero run.
    push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0, 1'b0);
    // Three pixels: opaque white, then alpha pixels whose alpha byte mode differs.
    push_byte(8'h00, 1'b1, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0, 1'b0);
    push_byte(8'h55, 1'b1, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0, 1'b0);
    // The end of the stream falls on the byte that completes a pixel.
    push_byte(8'h01, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h34, 1'b1, 1'b0, 1'b0);
    push_byte(8'h12, 1'b0, 1'b0, 1'b1);
    // A stream that ends inside its record, and one that is a single byte.
    push_byte(8'h05, 1'b1, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b1, 1'b1, 1'b1);

    for (int phase_idx = 0; phase_idx < 8; phase_idx++) begin
      wait_until_idle();
      start_val = 24'($urandom);
      stride_val = 13'($urandom_range(1, 4096));
      pitch_val = ($urandom_range(1) != 0) ? 13'($urandom_range(1, 64))
                                          : 13'($urandom_range(1, 4096));
      case (phase_idx)
        0: begin
          start_val = 24'hFFFFFF;
          stride_val = 13'h1FFF;
          pitch_val = 13'd1;
        end
        1: begin
          start_val = 24'h000000;
          stride_val = 13'd1;
          pitch_val = 13'h1FFF;
        end
        2: pitch_val = 13'd0;
        3: begin
          stride_val = 13'd4096;
          pitch_val = 13'd4096;
        end
        4: stride_val = 13'd0;
        default: ;
      endcase
      // Upper data bits are junk for the narrow registers and must be dropped.
      write_register(REG_START_ADDRESS, start_val);
      write_register(REG_ROW_STRIDE, {11'($urandom), stride_val});
      write_register(REG_ROW_PITCH, {11'($urandom), pitch_val});
      gap_pct = (phase_idx == 5) ? 0 : 13;
      @(posedge clk);
      phase_goal = bytes_queued + 150;
      while (bytes_queued < phase_goal) build_sprite();
    end

    while (bytes_taken != bytes_queued) @(posedge clk);
    while (writes_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("rle_sprite_blit_decoder test passed");
    end else begin
      $display("rle_sprite_blit_decoder test failed");
    end
    $finish;
  end
endmodule
